>>> hw/rtl/csiit_pkg.sv
// ----------------------------------------------------------------------------
// Crank sync timer package
// Shared widths, register indexes, control structs and an angle helper.
// ----------------------------------------------------------------------------
package csiit_pkg;

  localparam int CYL_N         = 4;
  localparam int TIME_W        = 48;
  localparam int ANG_W         = 10;
  localparam int CNT_W         = 8;
  localparam int DRV_W         = 4;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;
  localparam int INJ_PULSE_W   = 20;
  localparam int IGN_PULSE_W   = 16;
  localparam int IGN_ADV_W     = 9;
  localparam int TDC_REGS      = 4;

  localparam int CYCLE_DEG     = 720;
  localparam int REV_DEG       = 360;
  localparam int DEG_PER_TOOTH = 6;
  localparam int CNT_MAX       = 255;

  localparam logic [2:0] REG_TDC0      = 3'd0;
  localparam logic [2:0] REG_TDC1      = 3'd1;
  localparam logic [2:0] REG_TDC2      = 3'd2;
  localparam logic [2:0] REG_TDC3      = 3'd3;
  localparam logic [2:0] REG_INJ_LEAD  = 3'd4;
  localparam logic [2:0] REG_IGN_ADV   = 3'd5;
  localparam logic [2:0] REG_INJ_PULSE = 3'd6;
  localparam logic [2:0] REG_IGN_PULSE = 3'd7;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [ANG_W-1:0]  angle_t;

  typedef struct packed {
    logic [CYL_N-1:0][ANG_W-1:0] inj_start;
    logic [CYL_N-1:0][ANG_W-1:0] ign_start;
    logic [INJ_PULSE_W-1:0]      inj_pulse;
    logic [IGN_PULSE_W-1:0]      ign_pulse;
  } sched_cfg_t;

  typedef struct packed {
    logic   tooth;
    logic   synced;
    angle_t angle;
  } dec_out_t;

  function automatic angle_t start_angle(input angle_t tdc, input angle_t back);
    logic [11:0] s;
    s = 12'(tdc) + 12'(2 * CYCLE_DEG) - 12'(back);
    for (int k = 0; k < 3; k++) begin
      if (s >= 12'(CYCLE_DEG)) begin
        s = s - 12'(CYCLE_DEG);
      end
    end
    return s[ANG_W-1:0];
  endfunction

endpackage

>>> hw/rtl/csiit_cfg.sv
// ----------------------------------------------------------------------------
// Crank sync timer configuration registers
// APB-style register file; derives per-cylinder start angles.
// ----------------------------------------------------------------------------
module csiit_cfg
  import csiit_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output sched_cfg_t        cfg
);

  angle_t                 tdc_r [TDC_REGS];
  angle_t                 inj_lead_r;
  logic [IGN_ADV_W-1:0]   ign_adv_r;
  logic [INJ_PULSE_W-1:0] inj_pulse_r;
  logic [IGN_PULSE_W-1:0] ign_pulse_r;
  logic [2:0]             idx;
  logic                   wr;

  logic [CYL_N-1:0][ANG_W-1:0] inj_start_r;
  logic [CYL_N-1:0][ANG_W-1:0] ign_start_r;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tdc_r[0]    <= ANG_W'(0);
      tdc_r[1]    <= ANG_W'(180);
      tdc_r[2]    <= ANG_W'(360);
      tdc_r[3]    <= ANG_W'(540);
      inj_lead_r  <= ANG_W'(360);
      ign_adv_r   <= IGN_ADV_W'(12);
      inj_pulse_r <= INJ_PULSE_W'(10000);
      ign_pulse_r <= IGN_PULSE_W'(1000);
    end else if (wr) begin
      unique case (idx)
        REG_TDC0:      tdc_r[0]    <= pwdata[ANG_W-1:0];
        REG_TDC1:      tdc_r[1]    <= pwdata[ANG_W-1:0];
        REG_TDC2:      tdc_r[2]    <= pwdata[ANG_W-1:0];
        REG_TDC3:      tdc_r[3]    <= pwdata[ANG_W-1:0];
        REG_INJ_LEAD:  inj_lead_r  <= pwdata[ANG_W-1:0];
        REG_IGN_ADV:   ign_adv_r   <= pwdata[IGN_ADV_W-1:0];
        REG_INJ_PULSE: inj_pulse_r <= pwdata[INJ_PULSE_W-1:0];
        REG_IGN_PULSE: ign_pulse_r <= pwdata[IGN_PULSE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TDC0:      prdata = DATA_W'(tdc_r[0]);
      REG_TDC1:      prdata = DATA_W'(tdc_r[1]);
      REG_TDC2:      prdata = DATA_W'(tdc_r[2]);
      REG_TDC3:      prdata = DATA_W'(tdc_r[3]);
      REG_INJ_LEAD:  prdata = DATA_W'(inj_lead_r);
      REG_IGN_ADV:   prdata = DATA_W'(ign_adv_r);
      REG_INJ_PULSE: prdata = DATA_W'(inj_pulse_r);
      REG_IGN_PULSE: prdata = DATA_W'(ign_pulse_r);
    endcase
  end

  for (genvar i = 0; i < CYL_N; i++) begin : g_start
    always_ff @(posedge clk) begin
      inj_start_r[i] <= start_angle(tdc_r[i % TDC_REGS], inj_lead_r);
      ign_start_r[i] <= start_angle(tdc_r[i % TDC_REGS], ANG_W'(ign_adv_r));
    end
  end

  assign cfg.inj_start = inj_start_r;
  assign cfg.ign_start = ign_start_r;
  assign cfg.inj_pulse = inj_pulse_r;
  assign cfg.ign_pulse = ign_pulse_r;

endmodule

>>> hw/rtl/csiit_decode.sv
// ----------------------------------------------------------------------------
// Crank sync timer tooth decoder
// Detects crank edges, finds the missing-tooth gap, tracks cycle angle.
// ----------------------------------------------------------------------------
module csiit_decode
  import csiit_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  time_t    now,
  input  logic     crank,
  input  logic     cam,
  output dec_out_t dec
);

  logic              prev_r;
  time_t             last_r;
  logic [TIME_W:0]   thr_r;
  logic              pnz_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              sync_r;
  angle_t            angle_r;

  logic              rise;
  time_t             dt;
  logic              gap;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              sync_nxt;
  angle_t            angle_nxt;
  angle_t            off;
  logic [10:0]       raw;

  assign rise     = crank & ~prev_r;
  assign dt       = now - last_r;
  assign gap      = rise & pnz_r & ({1'b0, dt} > thr_r);
  assign cnt_inc  = (cnt_r == CNT_W'(CNT_MAX)) ? cnt_r : cnt_r + CNT_W'(1);
  assign sync_nxt = sync_r | gap;
  assign off      = cam ? ANG_W'(0) : ANG_W'(REV_DEG);

  always_comb begin
    priority if (gap) begin
      cnt_nxt = '0;
    end else if (rise) begin
      cnt_nxt = cnt_inc;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_comb begin
    raw = 11'(cnt_inc) * 11'(DEG_PER_TOOTH) + 11'(off);
    if (raw >= 11'(CYCLE_DEG)) begin
      raw = raw - 11'(CYCLE_DEG);
    end
    if (raw >= 11'(CYCLE_DEG)) begin
      raw = raw - 11'(CYCLE_DEG);
    end
    priority if (!(rise & sync_nxt)) begin
      angle_nxt = angle_r;
    end else if (gap) begin
      angle_nxt = off;
    end else begin
      angle_nxt = raw[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b0;
      last_r  <= '0;
      thr_r   <= '0;
      pnz_r   <= 1'b0;
      cnt_r   <= '0;
      sync_r  <= 1'b0;
      angle_r <= '0;
    end else if (step) begin
      prev_r  <= crank;
      cnt_r   <= cnt_nxt;
      sync_r  <= sync_nxt;
      angle_r <= angle_nxt;
      if (rise) begin
        last_r <= now;
        thr_r  <= {1'b0, dt} + {2'b0, dt[TIME_W-1:1]};
        pnz_r  <= (dt != '0);
      end
    end
  end

  assign dec.tooth  = rise & sync_nxt;
  assign dec.synced = sync_nxt;
  assign dec.angle  = angle_nxt;

endmodule

>>> hw/rtl/csiit_sched.sv
// ----------------------------------------------------------------------------
// Crank sync timer pulse scheduler
// Starts injection and ignition pulses at their angles, ends them on time.
// ----------------------------------------------------------------------------
module csiit_sched
  import csiit_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  time_t            now,
  input  dec_out_t         dec,
  input  sched_cfg_t       cfg,
  output logic [CYL_N-1:0] inj_lvl,
  output logic [CYL_N-1:0] ign_lvl
);

  logic [TIME_W:0] inj_sum;
  logic [TIME_W:0] ign_sum;
  logic            inj_quick;
  logic            ign_quick;

  assign inj_sum   = {1'b0, now} + (TIME_W + 1)'(cfg.inj_pulse);
  assign ign_sum   = {1'b0, now} + (TIME_W + 1)'(cfg.ign_pulse);
  assign inj_quick = (cfg.inj_pulse == '0) | inj_sum[TIME_W];
  assign ign_quick = (cfg.ign_pulse == '0) | ign_sum[TIME_W];

  for (genvar i = 0; i < CYL_N; i++) begin : g_cyl
    logic  inj_done_r, ign_done_r, inj_lvl_r, ign_lvl_r;
    time_t inj_end_r, ign_end_r;
    logic  inj_hit, ign_hit, inj_fire, ign_fire, inj_drop, ign_drop;

    assign inj_hit  = (dec.angle == cfg.inj_start[i]);
    assign ign_hit  = (dec.angle == cfg.ign_start[i]);
    assign inj_fire = dec.tooth & inj_hit & ~inj_done_r;
    assign ign_fire = dec.tooth & ign_hit & ~ign_done_r;
    assign inj_drop = inj_fire ? inj_quick : (now >= inj_end_r);
    assign ign_drop = ign_fire ? ign_quick : (now >= ign_end_r);
    assign inj_lvl[i] = (inj_fire | inj_lvl_r) & ~inj_drop;
    assign ign_lvl[i] = (ign_fire | ign_lvl_r) & ~ign_drop;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        inj_done_r <= 1'b0;
        ign_done_r <= 1'b0;
        inj_lvl_r  <= 1'b0;
        ign_lvl_r  <= 1'b0;
      end else if (step) begin
        inj_lvl_r <= inj_lvl[i];
        ign_lvl_r <= ign_lvl[i];
        if (dec.tooth) begin
          inj_done_r <= inj_hit;
          ign_done_r <= ign_hit;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (step && inj_fire) begin
        inj_end_r <= inj_sum[TIME_W-1:0];
      end
      if (step && ign_fire) begin
        ign_end_r <= ign_sum[TIME_W-1:0];
      end
    end
  end

endmodule

>>> hw/rtl/crank_sync_injection_ignition_timer_core.sv
// ----------------------------------------------------------------------------
// Crank sync injection and ignition timer core
// Path: input register, then result register; decoder and scheduler update in one pass.
// Throughput: one sample per cycle unless out_ready stalls the result register.
// Reset: rst_n synchronous, active low; clears sync, counters, pulses and registers
// to their defaults. Start angles are registered copies derived from the config registers.
// ----------------------------------------------------------------------------
module crank_sync_injection_ignition_timer_core
  import csiit_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  time_t             in_time_us,
  input  logic              in_crank_level,
  input  logic              in_cam_level,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DRV_W-1:0]  out_injector_drive,
  output logic [DRV_W-1:0]  out_ignition_drive,
  output logic              out_synced,
  output angle_t            out_cycle_angle,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic             s_v_r;
  time_t            s_time_r;
  logic             s_crank_r;
  logic             s_cam_r;
  logic             o_v_r;
  logic [DRV_W-1:0] o_inj_r;
  logic [DRV_W-1:0] o_ign_r;
  logic             o_sync_r;
  angle_t           o_angle_r;

  logic             adv;
  logic             take;
  sched_cfg_t       cfg;
  dec_out_t         dec;
  logic [CYL_N-1:0] inj_lvl;
  logic [CYL_N-1:0] ign_lvl;
  logic [DRV_W-1:0] inj_drv;
  logic [DRV_W-1:0] ign_drv;

  assign adv      = s_v_r & (~o_v_r | out_ready);
  assign in_ready = ~s_v_r | adv;
  assign take     = in_valid & in_ready;

  csiit_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  csiit_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .now   (s_time_r),
    .crank (s_crank_r),
    .cam   (s_cam_r),
    .dec   (dec)
  );

  csiit_sched u_sched (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .now     (s_time_r),
    .dec     (dec),
    .cfg     (cfg),
    .inj_lvl (inj_lvl),
    .ign_lvl (ign_lvl)
  );

  for (genvar b = 0; b < DRV_W; b++) begin : g_drv
    if (b < CYL_N) begin : g_on
      assign inj_drv[b] = inj_lvl[b];
      assign ign_drv[b] = ign_lvl[b];
    end else begin : g_off
      assign inj_drv[b] = 1'b0;
      assign ign_drv[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      s_v_r <= take | (s_v_r & ~adv);
      o_v_r <= adv | (o_v_r & ~out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s_time_r  <= in_time_us;
      s_crank_r <= in_crank_level;
      s_cam_r   <= in_cam_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_inj_r   <= '0;
      o_ign_r   <= '0;
      o_sync_r  <= 1'b0;
      o_angle_r <= '0;
    end else if (adv) begin
      o_inj_r   <= inj_drv;
      o_ign_r   <= ign_drv;
      o_sync_r  <= dec.synced;
      o_angle_r <= dec.angle;
    end
  end

  assign out_valid          = o_v_r;
  assign out_injector_drive = o_inj_r;
  assign out_ignition_drive = o_ign_r;
  assign out_synced         = o_sync_r;
  assign out_cycle_angle    = o_angle_r;

  a_sync_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(o_sync_r) |-> o_sync_r)
    else $error("sync flag dropped");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    o_angle_r < ANG_W'(CYCLE_DEG))
    else $error("cycle angle out of range");

  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (!o_v_r || out_ready) |-> in_ready)
    else $error("input stalled while result side is free");

  a_tooth_sync: assert property (@(posedge clk) disable iff (!rst_n)
    adv && dec.tooth |=> o_sync_r)
    else $error("synced tooth without sync on result");

endmodule
